/* rtl/core/piwe_pkg.sv */
// Shared types and constants of the pulse interval word encoder.
package piwe_pkg;

    localparam int ADDR_BITS     = 5;
    localparam int DATA_BITS     = 4;
    localparam int WORD_BITS     = ADDR_BITS + DATA_BITS;
    localparam int CAP_W         = 8;
    localparam int DUR_W         = 15;
    localparam int COPY_LEN      = WORD_BITS * 4 + 1;
    localparam int FRAME_RESULTS = COPY_LEN;
    localparam int POS_W         = $clog2(COPY_LEN);
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = DUR_W;

    localparam logic [POS_W-1:0] SYNC_POS  = POS_W'(COPY_LEN - 1);
    localparam logic [POS_W-1:0] LAST_PAIR = POS_W'(FRAME_RESULTS - 1);
    localparam logic [CAP_W-1:0] MIN_CAP   = CAP_W'(FRAME_RESULTS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT = 2'd0,
        CFG_LONG  = 2'd1,
        CFG_SYNC  = 2'd2,
        CFG_IDLE  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OVF
    } t_state;

    typedef struct packed {
        logic             emit;
        logic             ovf;
        logic             last;
        logic [POS_W-1:0] pos_a;
        logic [POS_W-1:0] pos_b;
    } t_seq_ctl;

endpackage

/* rtl/core/piwe_if.sv */
// Valid/ready channel interfaces for input items and result pairs.
interface piwe_in_if;
    logic       valid;
    logic       ready;
    logic [4:0] address;
    logic [3:0] payload;
    logic [7:0] capacity;

    modport source (output valid, address, payload, capacity, input ready);
    modport sink   (input valid, address, payload, capacity, output ready);
endinterface

interface piwe_out_if;
    logic        valid;
    logic        ready;
    logic [14:0] first_duration;
    logic        first_level;
    logic [14:0] second_duration;
    logic        second_level;
    logic        last;
    logic        overflow;

    modport source (output valid, first_duration, first_level, second_duration,
                    second_level, last, overflow, input ready);
    modport sink   (input valid, first_duration, first_level, second_duration,
                    second_level, last, overflow, output ready);
endinterface

/* rtl/core/piwe_dur.sv */
// Interval duration unit: maps two frame positions of a copy to durations.
module piwe_dur (
    input  logic [piwe_pkg::WORD_BITS-1:0] i_word,
    input  logic [piwe_pkg::DUR_W-1:0]     i_short,
    input  logic [piwe_pkg::DUR_W-1:0]     i_long,
    input  logic [piwe_pkg::DUR_W-1:0]     i_sync,
    input  logic [piwe_pkg::POS_W-1:0]     i_pos_a,
    input  logic [piwe_pkg::POS_W-1:0]     i_pos_b,
    output logic [piwe_pkg::DUR_W-1:0]     o_dur_a,
    output logic [piwe_pkg::DUR_W-1:0]     o_dur_b
);
    import piwe_pkg::*;

    function automatic logic [DUR_W-1:0] pick(
        input logic [POS_W-1:0]     pos,
        input logic [WORD_BITS-1:0] word,
        input logic [DUR_W-1:0]     s,
        input logic [DUR_W-1:0]     l,
        input logic [DUR_W-1:0]     y
    );
        logic [POS_W-3:0] bidx;
        logic             bit_val;
        begin
            bidx    = pos[POS_W-1:2];
            bit_val = word[bidx];
            if (pos == SYNC_POS) begin
                pick = y;
            end else if (bit_val ^ pos[0]) begin
                // one: long on even phase; zero: long on odd phase
                pick = l;
            end else begin
                pick = s;
            end
        end
    endfunction

    assign o_dur_a = pick(i_pos_a, i_word, i_short, i_long, i_sync);
    assign o_dur_b = pick(i_pos_b, i_word, i_short, i_long, i_sync);

endmodule

/* rtl/core/piwe_seq.sv */
// Frame sequencer: walks the interval positions of a frame, one pair a step.
module piwe_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [piwe_pkg::CAP_W-1:0] i_capacity,
    input  logic                       i_out_free,
    output logic                       o_in_ready,
    output piwe_pkg::t_seq_ctl         o_ctl
);
    import piwe_pkg::*;

    t_state           r_state, n_state;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_cnt, n_cnt;
    logic [POS_W:0]   pos_step;
    logic [POS_W-1:0] pos_next_a;
    logic [POS_W-1:0] pos_b;
    logic             accept;

    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign pos_step = {1'b0, r_pos} + (POS_W+1)'(2);
    // wrap into the second copy of the word
    assign pos_next_a = (pos_step >= (POS_W+1)'(COPY_LEN))
                      ? POS_W'(pos_step - (POS_W+1)'(COPY_LEN))
                      : pos_step[POS_W-1:0];
    assign pos_b = (r_pos == SYNC_POS) ? '0 : r_pos + POS_W'(1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_capacity < MIN_CAP) ? ST_OVF : ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_out_free && r_cnt == LAST_PAIR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_OVF: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_ctl.emit  = 1'b0;
        o_ctl.ovf   = 1'b0;
        o_ctl.last  = 1'b0;
        o_ctl.pos_a = r_pos;
        o_ctl.pos_b = pos_b;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                n_pos      = '0;
                n_cnt      = '0;
            end
            ST_RUN: begin
                o_ctl.emit = i_out_free;
                o_ctl.last = (r_cnt == LAST_PAIR);
                if (i_out_free) begin
                    n_pos = pos_next_a;
                    n_cnt = (r_cnt == LAST_PAIR) ? '0 : r_cnt + POS_W'(1);
                end
            end
            ST_OVF: begin
                o_ctl.emit = i_out_free;
                o_ctl.ovf  = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
        end
    end

`ifndef SYNTH
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= SYNC_POS && r_cnt <= LAST_PAIR)
        else $error("sequencer position out of range");
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && i_out_free && r_cnt == LAST_PAIR) |=> r_state == ST_IDLE)
        else $error("frame did not end after last pair");
    a_ovf_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OVF && i_out_free) |=> r_state == ST_IDLE)
        else $error("overflow result repeated");
`endif

endmodule

/* rtl/core/pulse_interval_word_encoder.sv */
// Top level: config registers, word latch, sequencer, duration unit, result register.
// First pair: run state entered on input transfer, registered once output is free.
// Throughput: 37 result pairs per item, one a cycle without back-pressure, set by
//   the sequencer stepping the shared duration unit once per pair.
// Overflow: one result, input ready again once it is registered.
// Reset (i_rst_n low, synchronous) clears config registers, sequencer, output valid.
module pulse_interval_word_encoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    piwe_in_if.sink                         i_in,
    piwe_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [piwe_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [piwe_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import piwe_pkg::*;

    logic [DUR_W-1:0]     r_short, r_long, r_sync;
    logic                 r_idle;
    logic [WORD_BITS-1:0] r_word;
    logic                 r_valid;
    logic [DUR_W-1:0]     r_dur_a, r_dur_b;
    logic                 r_lvl_a, r_lvl_b, r_last, r_ovf;
    logic                 out_free;
    logic                 in_ready;
    t_seq_ctl             ctl;
    logic [DUR_W-1:0]     dur_a, dur_b;

    assign out_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short <= '0;
            r_long  <= '0;
            r_sync  <= '0;
            r_idle  <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SHORT: r_short <= i_cfg_data;
                CFG_LONG:  r_long  <= i_cfg_data;
                CFG_SYNC:  r_sync  <= i_cfg_data;
                CFG_IDLE:  r_idle  <= i_cfg_data[0];
                default:   r_idle  <= r_idle;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) begin
            r_word <= {i_in.payload, i_in.address};
        end
    end

    piwe_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_capacity (i_in.capacity),
        .i_out_free (out_free),
        .o_in_ready (in_ready),
        .o_ctl      (ctl)
    );

    piwe_dur u_dur (
        .i_word  (r_word),
        .i_short (r_short),
        .i_long  (r_long),
        .i_sync  (r_sync),
        .i_pos_a (ctl.pos_a),
        .i_pos_b (ctl.pos_b),
        .o_dur_a (dur_a),
        .o_dur_b (dur_b)
    );

    // hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (out_free) begin
            r_valid <= ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && ctl.emit) begin
            r_dur_a <= ctl.ovf ? '0 : dur_a;
            r_dur_b <= ctl.ovf ? '0 : dur_b;
            r_lvl_a <= ctl.ovf ? 1'b0 : !r_idle;
            r_lvl_b <= ctl.ovf ? 1'b0 : r_idle;
            r_last  <= ctl.ovf ? 1'b0 : ctl.last;
            r_ovf   <= ctl.ovf;
        end
    end

    assign i_in.ready            = in_ready;
    assign o_out.valid           = r_valid;
    assign o_out.first_duration  = r_dur_a;
    assign o_out.first_level     = r_lvl_a;
    assign o_out.second_duration = r_dur_b;
    assign o_out.second_level    = r_lvl_b;
    assign o_out.last            = r_last;
    assign o_out.overflow        = r_ovf;

`ifndef SYNTH
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_ovf) |-> (r_dur_a == '0 && r_dur_b == '0 && !r_last
                                && !r_lvl_a && !r_lvl_b))
        else $error("overflow result carries data");
    a_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_ovf) |-> (r_lvl_a != r_lvl_b))
        else $error("pair levels do not alternate");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.emit) |-> !in_ready)
        else $error("input ready while frame in progress");
`endif

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the pulse interval word encoder.
`timescale 1ns / 1ps

module tb_top;
    import piwe_pkg::*;

    localparam int QUIET_LIMIT = 4000;

    typedef struct {
        logic [ADDR_BITS-1:0] address;
        logic [DATA_BITS-1:0] payload;
        logic [CAP_W-1:0]     capacity;
    } t_word;

    typedef struct {
        logic [DUR_W-1:0] first_duration;
        logic             first_level;
        logic [DUR_W-1:0] second_duration;
        logic             second_level;
        logic             last;
        logic             overflow;
    } t_pair;

    typedef enum int {
        RX_OPEN,
        RX_CHOPPY,
        RX_SLOW
    } t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    piwe_in_if  in_if ();
    piwe_out_if out_if ();

    pulse_interval_word_encoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // local copy of the register file
    logic [DUR_W-1:0] cfg_short = '0;
    logic [DUR_W-1:0] cfg_long  = '0;
    logic [DUR_W-1:0] cfg_sync  = '0;
    logic             cfg_idle  = 1'b0;

    t_word words_to_send[$];
    t_pair pairs_due[$];

    int mismatches  = 0;
    int pairs_seen  = 0;
    int gap_left    = 0;
    int burst_left  = 1;
    int mode_left   = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int quiet_count = 0;
    t_rx_mode rx_mode = RX_OPEN;

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("MISMATCH at pair %0d: %s", pairs_seen, msg);
    endtask

    function automatic logic [DUR_W-1:0] interval_length(input logic [WORD_BITS-1:0] word,
                                                          input int idx);
        int  pos;
        logic is_long;
        pos = idx % COPY_LEN;
        if (pos == COPY_LEN - 1)
            return cfg_sync;
        // a one bit starts long; every other interval swaps
        is_long = word[pos / 4] ^ pos[0];
        return is_long ? cfg_long : cfg_short;
    endfunction

    task automatic encode_word(input logic [ADDR_BITS-1:0] address,
                               input logic [DATA_BITS-1:0] payload,
                               input logic [CAP_W-1:0] capacity);
        t_pair p;
        logic [WORD_BITS-1:0] word;
        word = {payload, address};
        if (capacity < MIN_CAP) begin
            p = '{default: '0};
            p.overflow = 1'b1;
            pairs_due.push_back(p);
        end else begin
            for (int k = 0; k < FRAME_RESULTS; k++) begin
                p.first_duration  = interval_length(word, 2 * k);
                p.first_level     = ~cfg_idle;
                p.second_duration = interval_length(word, 2 * k + 1);
                p.second_level    = cfg_idle;
                p.last            = (k == FRAME_RESULTS - 1);
                p.overflow        = 1'b0;
                pairs_due.push_back(p);
            end
        end
    endtask

    // Driver: offer queued words in bursts, hold each until the transfer.
    always @(posedge i_clk) begin : feed
        t_word nxt;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready)
                encode_word(in_if.address, in_if.payload, in_if.capacity);
            if (!in_if.valid || in_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_if.valid <= 1'b0;
                end else if (words_to_send.size() > 0) begin
                    nxt = words_to_send.pop_front();
                    in_if.address  <= nxt.address;
                    in_if.payload  <= nxt.payload;
                    in_if.capacity <= nxt.capacity;
                    in_if.valid    <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each transfer against the oldest expected pair, pace ready.
    always @(posedge i_clk) begin : drain
        t_pair got;
        t_pair want;
        logic  take;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got.first_duration  = out_if.first_duration;
                got.first_level     = out_if.first_level;
                got.second_duration = out_if.second_duration;
                got.second_level    = out_if.second_level;
                got.last            = out_if.last;
                got.overflow        = out_if.overflow;
                if (pairs_due.size() == 0) begin
                    report("result with nothing expected");
                end else begin
                    want = pairs_due.pop_front();
                    if (got.first_duration !== want.first_duration)
                        report($sformatf("first_duration exp %0d got %0d",
                                         want.first_duration, got.first_duration));
                    if (got.first_level !== want.first_level)
                        report($sformatf("first_level exp %0b got %0b",
                                         want.first_level, got.first_level));
                    if (got.second_duration !== want.second_duration)
                        report($sformatf("second_duration exp %0d got %0d",
                                         want.second_duration, got.second_duration));
                    if (got.second_level !== want.second_level)
                        report($sformatf("second_level exp %0b got %0b",
                                         want.second_level, got.second_level));
                    if (got.last !== want.last)
                        report($sformatf("last exp %0b got %0b", want.last, got.last));
                    if (got.overflow !== want.overflow)
                        report($sformatf("overflow exp %0b got %0b",
                                         want.overflow, got.overflow));
                end
                pairs_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                take = 1'b0;
            end else if (!hold_done && pairs_seen >= 2000 && words_to_send.size() > 2) begin
                // back up the whole pipe while the driver keeps offering
                hold_done = 1'b1;
                hold_left = 500;
                take      = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(1, 60);
                end
                mode_left--;
                case (rx_mode)
                    RX_OPEN:   take = 1'b1;
                    RX_CHOPPY: take = 1'($urandom_range(0, 1));
                    default:   take = ($urandom_range(0, 3) == 0);
                endcase
            end
            out_if.ready <= take;
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_count = 0;
        else
            quiet_count++;
        if (quiet_count >= QUIET_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_SHORT: cfg_short = data;
            CFG_LONG:  cfg_long  = data;
            CFG_SYNC:  cfg_sync  = data;
            CFG_IDLE:  cfg_idle  = data[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_word(input int address, input int payload, input int capacity);
        t_word w;
        w.address  = ADDR_BITS'(address);
        w.payload  = DATA_BITS'(payload);
        w.capacity = CAP_W'(capacity);
        words_to_send.push_back(w);
    endtask

    // Wait until every word is in and every pair is out, then let the block drain.
    task automatic settle();
        do @(negedge i_clk);
        while (words_to_send.size() > 0 || in_if.valid || pairs_due.size() > 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_random(input logic [DUR_W-1:0] t_short, input logic [DUR_W-1:0] t_long,
                              input logic [DUR_W-1:0] t_sync, input logic [DUR_W-1:0] idle,
                              input int count);
        write_reg(CFG_SHORT, t_short);
        write_reg(CFG_LONG, t_long);
        write_reg(CFG_SYNC, t_sync);
        write_reg(CFG_IDLE, idle);
        @(negedge i_clk);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 85)
                send_word($urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(37, 255));
            else
                send_word($urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 36));
        end
        settle();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_SHORT;
        i_cfg_data      = '0;
        in_if.valid     = 1'b0;
        in_if.address   = '0;
        in_if.payload   = '0;
        in_if.capacity  = '0;
        out_if.ready    = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // registers at their reset values
        @(negedge i_clk);
        send_word(31, 15, 255);
        send_word(0, 0, 37);
        send_word(9, 6, 0);
        settle();

        write_reg(CFG_SHORT, 15'd100);
        write_reg(CFG_LONG, 15'd300);
        write_reg(CFG_SYNC, 15'd3000);
        write_reg(CFG_IDLE, 15'd0);
        @(negedge i_clk);
        send_word(0, 0, 255);
        send_word(31, 15, 255);
        send_word(5'h15, 4'hA, 37);
        send_word(5'h0A, 4'h5, 38);
        send_word(31, 15, 36);
        send_word(0, 0, 0);
        send_word(1, 8, 128);
        send_word(16, 1, 200);
        send_word(7, 3, 1);
        send_word(24, 12, 127);
        send_word(3, 0, 64);
        send_word(0, 15, 100);
        send_word(31, 0, 254);
        send_word(5'h12, 4'h9, 35);
        send_word(5'h0D, 4'h6, 37);
        settle();

        // extremes, with idle level taken from bit 0 of a wide value
        run_random(15'h7FFF, 15'h0000, 15'h7FFF, 15'h7FFF, 40);
        run_random(15'h0000, 15'h7FFF, 15'h0000, 15'h7FFE, 40);
        run_random(15'd1, 15'd32766, 15'd16384, 15'd1, 40);
        run_random(DUR_W'($urandom_range(0, 32767)), DUR_W'($urandom_range(0, 32767)),
                   DUR_W'($urandom_range(0, 32767)), DUR_W'($urandom_range(0, 32767)), 40);
        run_random(DUR_W'($urandom_range(0, 32767)), DUR_W'($urandom_range(0, 32767)),
                   DUR_W'($urandom_range(0, 32767)), DUR_W'($urandom_range(0, 32767)), 40);

        repeat (20) @(negedge i_clk);
        if (pairs_due.size() > 0)
            report($sformatf("%0d expected pairs never arrived", pairs_due.size()));
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/piwe_pkg.sv
rtl/core/piwe_if.sv
rtl/core/piwe_dur.sv
rtl/core/piwe_seq.sv
rtl/core/pulse_interval_word_encoder.sv
dv/tb_top.sv
